// ===== rtl/bavg_pkg.sv =====
package bavg_pkg;

   localparam int MAX_GRID_DEF    = 4096;
   localparam int MAX_DISPLAY_DEF = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int GRID_W  = 13;
   localparam int DISP_W  = 7;
   localparam int SUM_W   = 40;
   localparam int AREA_W  = 2 * GRID_W;
   localparam int IDX_W   = 6;
   localparam int CSR_W   = 2;
   localparam int CSR_DW  = GRID_W;

   localparam logic [CSR_W-1:0] CSR_GRID_SIZE    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_DISPLAY_SIZE = 2'd1;

   localparam logic [GRID_W-1:0] GRID_RESET = 13'd128;
   localparam logic [DISP_W-1:0] DISP_RESET = 7'd13;

endpackage

// ===== rtl/block_average_downsampler.sv =====
// path: a block-completing sample's sum passes the stage-1 read-modify-write, the 40-step
//    serial divide and a hold state before it reaches the output register on the rsp side
// throughput: one sample per cycle; after a block-completing sample the req side stalls
//    until the 40-step divider hands its quotient to the output register
// reset (synchronous) and a csr write to either register clear the column-sum valid bits
//    at once and run the setup (load, 13-step block-side divide, then area) with req_tready low
module block_average_downsampler
   import bavg_pkg::*;
#(
   parameter int MAX_GRID    = MAX_GRID_DEF,
   parameter int MAX_DISPLAY = MAX_DISPLAY_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_W-1:0]      csr_index,
   input  logic [CSR_DW-1:0]     csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // average, block_row, block_col
   output logic [((SAMPLE_BITS+2*IDX_W+7)/8)*8-1:0] rsp_tdata,
   // last
   output logic                  rsp_tlast
);

   localparam int RSP_W  = ((SAMPLE_BITS + 2 * IDX_W + 7) / 8) * 8;
   localparam int ADDR_W = (MAX_DISPLAY > 1) ? $clog2(MAX_DISPLAY) : 1;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int SCNT_W = $clog2(GRID_W + 1);

   localparam logic [1:0] SU_LOAD  = 2'd0;
   localparam logic [1:0] SU_DIV   = 2'd1;
   localparam logic [1:0] SU_AREA  = 2'd2;
   localparam logic [1:0] SU_READY = 2'd3;

   localparam logic [1:0] DV_IDLE = 2'd0;
   localparam logic [1:0] DV_RUN  = 2'd1;
   localparam logic [1:0] DV_HOLD = 2'd2;

   // configuration
   logic [GRID_W-1:0] grid_size_ff;
   logic [DISP_W-1:0] display_size_ff;
   logic [GRID_W-1:0] eff_grid;
   logic [DISP_W-1:0] eff_disp;

   // setup divider
   logic [1:0]        su_state_ff;
   logic [SCNT_W-1:0] su_cnt_ff;
   logic [DISP_W-1:0] su_rem_ff;
   logic [GRID_W-1:0] su_quo_ff;
   logic [DISP_W:0]   su_trial;
   logic [GRID_W-1:0] side_ff;
   logic [AREA_W-1:0] area_ff;

   // frame counters
   logic [GRID_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [GRID_W-1:0] cc_ff, cc_in, rr_ff, rr_in;
   logic [GRID_W-1:0] bc_ff, bc_in, br_ff, br_in;

   // stage 1
   logic              s1_valid_ff;
   logic              s1_emit_ff;
   logic              s1_last_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [IDX_W-1:0]  s1_row_ff, s1_col_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;

   // column sums
   logic [SUM_W-1:0]  sums_mem [MAX_DISPLAY];
   logic [MAX_DISPLAY-1:0] sum_vld_ff;
   logic [SUM_W-1:0]  rd_data_ff;
   logic              fwd_ff;
   logic [SUM_W-1:0]  fwd_data_ff;
   logic [SUM_W-1:0]  base_sum, new_sum, wr_data;

   // block divider
   logic [1:0]        dv_state_ff;
   logic [DCNT_W-1:0] dv_cnt_ff;
   logic [AREA_W-1:0] dv_rem_ff;
   logic [SUM_W-1:0]  dv_quo_ff;
   logic [AREA_W:0]   dv_trial;
   logic              dv_last_ff;
   logic [IDX_W-1:0]  dv_row_ff, dv_col_ff;

   // output register
   logic              out_valid_ff;
   logic [SAMPLE_BITS-1:0] out_avg_ff;
   logic [IDX_W-1:0]  out_row_ff, out_col_ff;
   logic              out_last_ff;

   logic              accept;
   logic              restart;
   logic              covered;
   logic [ADDR_W-1:0] s0_addr;

   always_comb begin
      eff_grid = grid_size_ff;
      if (grid_size_ff == '0) begin
         eff_grid = GRID_W'(1);
      end else if (32'(grid_size_ff) > MAX_GRID) begin
         eff_grid = GRID_W'(MAX_GRID);
      end
      eff_disp = display_size_ff;
      if (display_size_ff == '0) begin
         eff_disp = DISP_W'(1);
      end else if (32'(display_size_ff) > MAX_DISPLAY) begin
         eff_disp = DISP_W'(MAX_DISPLAY);
      end
   end

   assign restart    = csr_we && (csr_index == CSR_GRID_SIZE || csr_index == CSR_DISPLAY_SIZE);
   assign req_tready = (su_state_ff == SU_READY) && (dv_state_ff == DV_IDLE)
                       && !(s1_valid_ff && s1_emit_ff);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff    <= GRID_RESET;
         display_size_ff <= DISP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_SIZE:    grid_size_ff    <= csr_wdata;
            CSR_DISPLAY_SIZE: display_size_ff <= csr_wdata[DISP_W-1:0];
            default: ;
         endcase
      end
   end

   // block side = eff_grid / eff_disp, restoring
   assign su_trial = {su_rem_ff, su_quo_ff[GRID_W-1]};

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         su_state_ff <= SU_LOAD;
         su_cnt_ff   <= '0;
      end else begin
         unique case (su_state_ff)
            SU_LOAD: begin
               su_rem_ff   <= '0;
               su_quo_ff   <= eff_grid;
               su_cnt_ff   <= '0;
               su_state_ff <= SU_DIV;
            end
            SU_DIV: begin
               if (su_trial >= {1'b0, eff_disp}) begin
                  su_rem_ff <= DISP_W'(su_trial - {1'b0, eff_disp});
                  su_quo_ff <= {su_quo_ff[GRID_W-2:0], 1'b1};
               end else begin
                  su_rem_ff <= su_trial[DISP_W-1:0];
                  su_quo_ff <= {su_quo_ff[GRID_W-2:0], 1'b0};
               end
               su_cnt_ff <= su_cnt_ff + SCNT_W'(1);
               if (su_cnt_ff == SCNT_W'(GRID_W - 1)) begin
                  su_state_ff <= SU_AREA;
               end
            end
            SU_AREA: begin
               side_ff     <= su_quo_ff;
               area_ff     <= AREA_W'(su_quo_ff * su_quo_ff);
               su_state_ff <= SU_READY;
            end
            default: ;
         endcase
      end
   end

   // counters for the next sample
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cc_in  = cc_ff;
      rr_in  = rr_ff;
      bc_in  = bc_ff;
      br_in  = br_ff;
      if ({1'b0, col_ff} + (GRID_W + 1)'(1) >= {1'b0, eff_grid}) begin
         col_in = '0;
         cc_in  = '0;
         bc_in  = '0;
         if ({1'b0, row_ff} + (GRID_W + 1)'(1) >= {1'b0, eff_grid}) begin
            row_in = '0;
            rr_in  = '0;
            br_in  = '0;
         end else begin
            row_in = row_ff + GRID_W'(1);
            if (rr_ff == side_ff - GRID_W'(1)) begin
               rr_in = '0;
               br_in = br_ff + GRID_W'(1);
            end else begin
               rr_in = rr_ff + GRID_W'(1);
            end
         end
      end else begin
         col_in = col_ff + GRID_W'(1);
         if (cc_ff == side_ff - GRID_W'(1)) begin
            cc_in = '0;
            bc_in = bc_ff + GRID_W'(1);
         end else begin
            cc_in = cc_ff + GRID_W'(1);
         end
      end
   end

   assign covered = (side_ff != '0) && (bc_ff < GRID_W'(eff_disp))
                    && (br_ff < GRID_W'(eff_disp));
   assign s0_addr = ADDR_W'(bc_ff);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
         cc_ff  <= '0;
         rr_ff  <= '0;
         bc_ff  <= '0;
         br_ff  <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cc_ff  <= cc_in;
         rr_ff  <= rr_in;
         bc_ff  <= bc_in;
         br_ff  <= br_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept && covered;
         fwd_ff      <= s1_valid_ff && (s1_addr_ff == s0_addr);
      end
      fwd_data_ff  <= wr_data;
      s1_emit_ff   <= (cc_ff == side_ff - GRID_W'(1)) && (rr_ff == side_ff - GRID_W'(1));
      s1_last_ff   <= (bc_ff == GRID_W'(eff_disp) - GRID_W'(1))
                      && (br_ff == GRID_W'(eff_disp) - GRID_W'(1));
      s1_addr_ff   <= s0_addr;
      s1_row_ff    <= br_ff[IDX_W-1:0];
      s1_col_ff    <= bc_ff[IDX_W-1:0];
      s1_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
   end

   // read-modify-write of the column sum
   always_comb begin
      if (fwd_ff) begin
         base_sum = fwd_data_ff;
      end else if (sum_vld_ff[s1_addr_ff]) begin
         base_sum = rd_data_ff;
      end else begin
         base_sum = '0;
      end
      new_sum = base_sum + SUM_W'(s1_sample_ff);
      wr_data = s1_emit_ff ? '0 : new_sum;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= sums_mem[s0_addr];
      if (s1_valid_ff) begin
         sums_mem[s1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         sum_vld_ff <= '0;
      end else if (s1_valid_ff) begin
         sum_vld_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // block sum / area, restoring
   assign dv_trial = {dv_rem_ff, dv_quo_ff[SUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         dv_state_ff <= DV_IDLE;
         dv_cnt_ff   <= '0;
      end else begin
         unique case (dv_state_ff)
            DV_IDLE: begin
               if (s1_valid_ff && s1_emit_ff) begin
                  dv_rem_ff   <= '0;
                  dv_quo_ff   <= new_sum;
                  dv_cnt_ff   <= '0;
                  dv_row_ff   <= s1_row_ff;
                  dv_col_ff   <= s1_col_ff;
                  dv_last_ff  <= s1_last_ff;
                  dv_state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               if (dv_trial >= {1'b0, area_ff}) begin
                  dv_rem_ff <= AREA_W'(dv_trial - {1'b0, area_ff});
                  dv_quo_ff <= {dv_quo_ff[SUM_W-2:0], 1'b1};
               end else begin
                  dv_rem_ff <= dv_trial[AREA_W-1:0];
                  dv_quo_ff <= {dv_quo_ff[SUM_W-2:0], 1'b0};
               end
               dv_cnt_ff <= dv_cnt_ff + DCNT_W'(1);
               if (dv_cnt_ff == DCNT_W'(SUM_W - 1)) begin
                  dv_state_ff <= DV_HOLD;
               end
            end
            DV_HOLD: begin
               if (!out_valid_ff || rsp_tready) begin
                  dv_state_ff <= DV_IDLE;
               end
            end
            default: dv_state_ff <= DV_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         out_valid_ff <= 1'b0;
      end else if (dv_state_ff == DV_HOLD && (!out_valid_ff || rsp_tready)) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (dv_state_ff == DV_HOLD && (!out_valid_ff || rsp_tready)) begin
         out_avg_ff  <= dv_quo_ff[SAMPLE_BITS-1:0];
         out_row_ff  <= dv_row_ff;
         out_col_ff  <= dv_col_ff;
         out_last_ff <= dv_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_col_ff, out_row_ff, out_avg_ff});
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== verif/bavg_checker.sv =====
module bavg_checker
   import bavg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  logic              req_tvalid,
   input  logic              req_tready,
   // sample
   input  logic [((SAMPLE_BITS_DEF+7)/8)*8-1:0] req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   // average, block_row, block_col
   input  logic [((SAMPLE_BITS_DEF+2*IDX_W+7)/8)*8-1:0] rsp_tdata,
   // last
   input  logic              rsp_tlast,
   output int                fail_count,
   output int                outstanding,
   output int                blocks_checked
);

   typedef struct packed {
      logic [SAMPLE_BITS_DEF-1:0] average;
      logic [IDX_W-1:0]           block_row;
      logic [IDX_W-1:0]           block_col;
      logic                       last;
   } block_avg_type;

   logic [GRID_W-1:0] grid_setting;
   logic [DISP_W-1:0] display_setting;
   logic [11:0]       row_pos;
   logic [11:0]       col_pos;
   logic [GRID_W-1:0] block_side;
   logic [SUM_W-1:0]  strip_sums [MAX_DISPLAY_DEF];
   block_avg_type     expected_blocks [$];
   int                errors = 0;
   int                matched = 0;

   function automatic int grid_in_use();
      if (grid_setting == '0) return 1;
      if (int'(grid_setting) > MAX_GRID_DEF) return MAX_GRID_DEF;
      return int'(grid_setting);
   endfunction

   function automatic int display_in_use();
      if (display_setting == '0) return 1;
      if (int'(display_setting) > MAX_DISPLAY_DEF) return MAX_DISPLAY_DEF;
      return int'(display_setting);
   endfunction

   function automatic void restart_frame();
      row_pos = '0;
      col_pos = '0;
      block_side = GRID_W'(grid_in_use() / display_in_use());
      for (int k = 0; k < MAX_DISPLAY_DEF; k++) strip_sums[k] = '0;
   endfunction

   function automatic void accumulate_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
      int grid_n;
      int disp_n;
      int side_n;
      int covered;
      int br;
      int bc;
      logic [SUM_W-1:0] acc;
      logic [SUM_W-1:0] area;
      block_avg_type blk;
      grid_n = grid_in_use();
      disp_n = display_in_use();
      side_n = int'(block_side);
      covered = side_n * disp_n;
      if (side_n != 0 && int'(row_pos) < covered && int'(col_pos) < covered) begin
         br = int'(row_pos) / side_n;
         bc = int'(col_pos) / side_n;
         if (bc < MAX_DISPLAY_DEF) begin
            acc = strip_sums[bc] + SUM_W'(s);
            if (int'(row_pos) % side_n == side_n - 1 && int'(col_pos) % side_n == side_n - 1) begin
               area = SUM_W'(side_n) * SUM_W'(side_n);
               blk.average = SAMPLE_BITS_DEF'(acc / area);
               blk.block_row = IDX_W'(br);
               blk.block_col = IDX_W'(bc);
               blk.last = (br == disp_n - 1 && bc == disp_n - 1);
               expected_blocks.push_back(blk);
               strip_sums[bc] = '0;
            end else begin
               strip_sums[bc] = acc;
            end
         end
      end
      // raster advance with frame wrap
      if (int'(col_pos) + 1 >= grid_n) begin
         col_pos = '0;
         row_pos = (int'(row_pos) + 1 >= grid_n) ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endfunction

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      block_avg_type want;
      block_avg_type got;
      if (reset) begin
         grid_setting = GRID_RESET;
         display_setting = DISP_RESET;
         restart_frame();
         expected_blocks.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_SIZE: begin
                  grid_setting = csr_wdata[GRID_W-1:0];
                  restart_frame();
               end
               CSR_DISPLAY_SIZE: begin
                  display_setting = csr_wdata[DISP_W-1:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) accumulate_sample(req_tdata[SAMPLE_BITS_DEF-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            got.average = rsp_tdata[SAMPLE_BITS_DEF-1:0];
            got.block_row = rsp_tdata[SAMPLE_BITS_DEF +: IDX_W];
            got.block_col = rsp_tdata[SAMPLE_BITS_DEF+IDX_W +: IDX_W];
            got.last = rsp_tlast;
            if (expected_blocks.size() == 0) begin
               $display({"%0t unexpected transaction: expected none",
                         " actual average %0d row %0d col %0d last %0d"},
                        $time, got.average, got.block_row, got.block_col, got.last);
               errors++;
            end else begin
               want = expected_blocks.pop_front();
               check_field("average", want.average, got.average);
               check_field("block_row", want.block_row, got.block_row);
               check_field("block_col", want.block_col, got.block_col);
               check_field("last", want.last, got.last);
               matched++;
            end
         end
      end
      fail_count <= errors;
      outstanding <= expected_blocks.size();
      blocks_checked <= matched;
   end

endmodule

// ===== verif/tb_block_average_downsampler.sv =====
module tb_block_average_downsampler;
   import bavg_pkg::*;

   localparam int REQ_W = ((SAMPLE_BITS_DEF+7)/8)*8;
   localparam int RSP_W = ((SAMPLE_BITS_DEF+2*IDX_W+7)/8)*8;
   localparam int DRAIN_PAD = 60;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 520;
   localparam logic [CSR_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_W-1:0] CSR_SPARE_B = 2'd3;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_index;
   logic [CSR_DW-1:0] csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;

   int                fail_count;
   int                outstanding;
   int                blocks_checked;
   int                samples_sent = 0;
   int                settings_written = 0;
   int                idle_cycles = 0;
   logic [GRID_W-1:0] cur_grid = GRID_RESET;
   bit                hold_off_req = 1'b0;
   bit                hold_off_done = 1'b0;

   block_average_downsampler uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   bavg_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .blocks_checked (blocks_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t no transaction for %0d cycles, %0d blocks outstanding",
                  $time, idle_cycles, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_BITS_DEF-1:0] random_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return SAMPLE_BITS_DEF'($urandom_range(0, 65535));
   endfunction

   task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] v, input int gap_after);
      req_tdata <= REQ_W'(v);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
      if (gap_after > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_after) @(posedge clock);
      end
   endtask

   task automatic stream_samples(input int count, input bit idle_on);
      for (int k = 0; k < count; k++) send_sample(random_sample(), idle_on ? pick_gap() : 0);
   endtask

   // wait until every block average is back and the divider is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_W-1:0] idx, input logic [CSR_DW-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_written++;
      if (idx == CSR_GRID_SIZE) cur_grid = val[GRID_W-1:0];
   endtask

   task automatic random_setting();
      logic [CSR_DW-1:0] g_val;
      logic [CSR_DW-1:0] d_val;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) g_val = CSR_DW'($urandom_range(1, 12));
      else if (pick < 9) g_val = CSR_DW'($urandom_range(13, 40));
      else g_val = CSR_DW'($urandom_range(0, 8191));
      pick = $urandom_range(0, 9);
      if (pick < 8) d_val = CSR_DW'($urandom_range(1, 6));
      else d_val = CSR_DW'($urandom_range(0, 127));
      // upper bits beyond the display width are dropped by the block
      d_val = d_val | CSR_DW'($urandom_range(0, 63) << DISP_W);
      pick = $urandom_range(0, 9);
      case (pick)
         0: ;
         1: write_config(CSR_GRID_SIZE, g_val);
         2: write_config(CSR_DISPLAY_SIZE, d_val);
         3: begin
            write_config(CSR_DISPLAY_SIZE, d_val);
            write_config(CSR_GRID_SIZE, g_val);
         end
         default: begin
            write_config(CSR_GRID_SIZE, g_val);
            write_config(CSR_DISPLAY_SIZE, d_val);
         end
      endcase
   endtask

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      int base;
      int eg;
      int frame_len;
      int count;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_GRID_SIZE;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      settle();

      // reset settings, no block completes this early
      stream_samples(6, 1'b1);
      settle();
      // display larger than grid: zero block side
      write_config(CSR_GRID_SIZE, CSR_DW'(1));
      stream_samples(3, 1'b0);
      settle();
      // one sample per block
      write_config(CSR_DISPLAY_SIZE, CSR_DW'(1));
      send_sample(16'h0000, 0);
      send_sample(16'hFFFF, 1);
      send_sample(16'h8001, 0);
      send_sample(16'h7FFE, 0);
      settle();
      // zero registers act as one
      write_config(CSR_GRID_SIZE, CSR_DW'(0));
      write_config(CSR_DISPLAY_SIZE, CSR_DW'(0));
      stream_samples(2, 1'b0);
      settle();
      // oversized registers clamp
      write_config(CSR_GRID_SIZE, '1);
      write_config(CSR_DISPLAY_SIZE, CSR_DW'(127));
      stream_samples(3, 1'b1);
      settle();
      // unused indexes must leave a half-done block alone
      write_config(CSR_GRID_SIZE, CSR_DW'(2));
      write_config(CSR_DISPLAY_SIZE, CSR_DW'(1));
      send_sample(16'hFFFF, 0);
      send_sample(16'hFFFF, 0);
      settle();
      write_config(CSR_SPARE_A, CSR_DW'($urandom));
      write_config(CSR_SPARE_B, CSR_DW'($urandom));
      send_sample(16'hFFFF, 0);
      send_sample(16'hFFFE, 0);
      settle();

      base = samples_sent;
      // full-width row of single-sample blocks while the receiver holds off
      write_config(CSR_GRID_SIZE, CSR_DW'(64));
      write_config(CSR_DISPLAY_SIZE, CSR_DW'(100));
      hold_off_req = 1'b1;
      stream_samples(100, 1'b0);
      settle();

      while (samples_sent < base + RANDOM_ITEMS) begin
         random_setting();
         eg = (cur_grid == '0) ? 1
              : ((int'(cur_grid) > MAX_GRID_DEF) ? MAX_GRID_DEF : int'(cur_grid));
         frame_len = eg * eg;
         if (frame_len > 200) begin
            count = $urandom_range(20, 200);
         end else begin
            count = frame_len * $urandom_range(1, 2);
            if ($urandom_range(0, 1) == 1) count += $urandom_range(0, frame_len - 1);
         end
         if (count > 250) count = 250;
         stream_samples(count, $urandom_range(0, 3) != 0);
         settle();
      end

      $display("%0d samples streamed across %0d register writes, %0d block averages compared",
               samples_sent, settings_written, blocks_checked);
      $display("settings spanned single-sample blocks, clamped and zero registers, zero block side");
      if (fail_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
